// ----- hdl/qws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qws_pkg
// Shared types and constants of the quoted word splitter.
// ----------------------------------------------------------------------------
package qws_pkg;

    localparam int CHAR_W = 8;

    // kind field codes
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // special bytes
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } qmode_t;

    typedef struct packed {
        logic   escape_pending;
        qmode_t quote_mode;
        logic   word_open;
    } split_state_t;

    localparam split_state_t STATE_CLEAR = '{
        escape_pending: 1'b0,
        quote_mode:     QM_NONE,
        word_open:      1'b0
    };

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              word_end;
        logic              string_done;
    } split_result_t;

endpackage : qws_pkg
`default_nettype wire

// ----- hdl/qws_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qws_step
// Per-byte splitting rule: next state and optional result for one item.
// ----------------------------------------------------------------------------
module qws_step (
    input  wire qws_pkg::split_state_t  cur,
    input  wire logic                   kind,
    input  wire logic [7:0]             ch,
    output qws_pkg::split_state_t       nxt,
    output qws_pkg::split_result_t      res
);
    import qws_pkg::*;

    logic is_end;
    logic is_ws;
    logic close_quote;

    assign is_end = (kind == KIND_END) || (ch == CH_NUL);
    assign is_ws  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    assign close_quote = ((cur.quote_mode == QM_SINGLE) && (ch == CH_SQUOTE)) ||
                         ((cur.quote_mode == QM_DOUBLE) && (ch == CH_DQUOTE));

    always_comb
    begin
        nxt = cur;
        res = '{valid: 1'b0, out_char: CH_NUL, char_valid: 1'b0,
                word_end: 1'b0, string_done: 1'b0};

        if (is_end)
        begin
            // flush: dangling backslash wins, then open word, else bare done
            nxt             = STATE_CLEAR;
            res.valid       = 1'b1;
            res.string_done = 1'b1;
            if (cur.escape_pending)
            begin
                res.out_char   = CH_BACKSLASH;
                res.char_valid = 1'b1;
                res.word_end   = 1'b1;
            end
            else if (cur.word_open)
            begin
                res.word_end = 1'b1;
            end
        end
        else if (cur.escape_pending)
        begin
            nxt.escape_pending = 1'b0;
            nxt.word_open      = 1'b1;
            res.valid          = 1'b1;
            res.out_char       = ch;
            res.char_valid     = 1'b1;
        end
        else if (ch == CH_BACKSLASH)
        begin
            nxt.escape_pending = 1'b1;
        end
        else if (cur.quote_mode != QM_NONE)
        begin
            if (close_quote)
            begin
                nxt.quote_mode = QM_NONE;
            end
            else
            begin
                nxt.word_open  = 1'b1;
                res.valid      = 1'b1;
                res.out_char   = ch;
                res.char_valid = 1'b1;
            end
        end
        else if (ch == CH_SQUOTE)
        begin
            nxt.quote_mode = QM_SINGLE;
        end
        else if (ch == CH_DQUOTE)
        begin
            nxt.quote_mode = QM_DOUBLE;
        end
        else if (is_ws)
        begin
            if (cur.word_open)
            begin
                nxt.word_open = 1'b0;
                res.valid     = 1'b1;
                res.word_end  = 1'b1;
            end
        end
        else
        begin
            nxt.word_open  = 1'b1;
            res.valid      = 1'b1;
            res.out_char   = ch;
            res.char_valid = 1'b1;
        end
    end

endmodule : qws_step
`default_nettype wire

// ----- hdl/quoted_word_splitter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_word_splitter_unit
// Shell-like word splitter: one byte in per transfer, word characters and
// word/string boundaries out as a stream.
// ----------------------------------------------------------------------------
//  channel | dir | tdata            | tuser                        | tlast
//  s_*     | in  | [7:0] ch         | [0] kind (0 char, 1 end)     | -
//  m_*     | out | [7:0] out_char   | [0] char_valid [1] string_done | word_end
//
//  Flow: one transfer accepted per clock while s_tready is high; a result is
//  registered in the result register (or the skid register while m_* stalls).
//  The splitting state (escape, quote mode, word open) updates in the same
//  edge that accepts a byte, so the per-byte rule is the only loop.
//  Reset (rst_n low, async) clears the state and empties both output slots.
//  Stalls: a two-entry output (result register plus skid register) keeps
//  s_tready a register; it drops only while both entries are full.
// ----------------------------------------------------------------------------
module quoted_word_splitter_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic       s_tuser,   // [0] kind
    // output stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_char
    output logic [1:0]      m_tuser,   // [0] char_valid, [1] string_done
    output logic            m_tlast    // word_end
);
    import qws_pkg::*;

    split_state_t  state_reg;
    split_state_t  state_next;
    split_result_t step_res;

    // result register and skid entry (valid bit lives in the struct)
    split_result_t out_reg, out_next;
    split_result_t skid_reg, skid_next;

    logic s_xfer;
    logic out_free;

    assign s_tready = ~skid_reg.valid;
    assign s_xfer   = s_tvalid & s_tready;
    assign out_free = ~out_reg.valid | m_tready;

    qws_step u_step (
        .cur  (state_reg),
        .kind (s_tuser),
        .ch   (s_tdata),
        .nxt  (state_next),
        .res  (step_res)
    );

    // output slot steering
    always_comb
    begin
        split_result_t incoming;
        incoming       = step_res;
        incoming.valid = step_res.valid & s_xfer;
        out_next  = out_reg;
        skid_next = skid_reg;
        if (out_free)
        begin
            if (skid_reg.valid)
            begin
                out_next  = skid_reg;
                skid_next = incoming;   // no transfer when skid is full
            end
            else
            begin
                out_next = incoming;
            end
        end
        else if (incoming.valid)
        begin
            skid_next = incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
            out_reg   <= '0;
            skid_reg  <= '0;
        end
        else
        begin
            if (s_xfer)
            begin
                state_reg <= state_next;
            end
            out_reg  <= out_next;
            skid_reg <= skid_next;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = out_reg.out_char;
    assign m_tuser  = {out_reg.string_done, out_reg.char_valid};
    assign m_tlast  = out_reg.word_end;

`ifndef NO_ASSERTIONS
    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_reg.valid |-> out_reg.valid)
        else $error("skid entry valid while result register empty");

    // an end item always leaves a result waiting
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && s_tuser == KIND_END) |=> m_tvalid)
        else $error("end item produced no result");

    // an end item clears all splitting state
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && s_tuser == KIND_END) |=> (state_reg == STATE_CLEAR))
        else $error("state not cleared after end item");

    // a result with neither character nor word end must close the string
    a_no_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0] && !m_tlast) |-> m_tuser[1])
        else $error("empty result without string_done");

    // a result without a character carries a zero byte
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == CH_NUL))
        else $error("out_char nonzero without char_valid");
`endif

endmodule : quoted_word_splitter_unit
`default_nettype wire
